// ===== sv/nbcf_pkg.sv =====
// Shared types and constants for the newline and brace-count command framer.
package nbcf_pkg;

    // Frame limits and field widths
    localparam int MAX_FRAME_BYTES = 4096;
    localparam int HANDLE_W        = 16;
    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 13;
    localparam int BAL_W           = 14;
    localparam int KIND_W          = 2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    // Characters with a framing meaning
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT    = 2'd2;

    // Item modes
    localparam logic MODE_BYTE       = 1'b0;
    localparam logic MODE_DISCONNECT = 1'b1;

    // One input request
    typedef struct packed {
        logic                mode;
        logic [HANDLE_W-1:0] target_handle;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_in_write;
    } item_t;

    // One result without its last flag
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic [CNT_W-1:0]  frame_length;
    } result_t;

    // Up to two results caused by one request
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } pair_t;

endpackage

// ===== sv/nbcf_if.sv =====
// Valid/ready channel interfaces for requests and results of the framer.
interface nbcf_req_if;
    import nbcf_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [HANDLE_W-1:0] target_handle;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_in_write;

    modport source (output valid, mode, target_handle, data_byte, last_in_write,
                    input ready);
    modport sink   (input valid, mode, target_handle, data_byte, last_in_write,
                    output ready);
endinterface

interface nbcf_res_if;
    import nbcf_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  frame_length;
    logic              last;

    modport source (output valid, kind, out_byte, frame_length, last, input ready);
    modport sink   (input valid, kind, out_byte, frame_length, last, output ready);
endinterface

// ===== sv/nbcf_frame_logic.sv =====
// Frame state registers and the per-request framing decision.
module nbcf_frame_logic
    import nbcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [HANDLE_W-1:0] control_handle,
    input  item_t               item,
    input  logic                advance,
    output pair_t               pair
);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [BAL_W-1:0] bal_reg,  bal_next;
    logic             bwb_reg,  bwb_next;

    // Decide results and the next frame state for the held request
    always_comb
    begin
        logic    is_eol;
        result_t res0;
        result_t res1;
        logic [1:0] n;
        res0     = '0;
        res1     = '0;
        n        = 2'd0;
        cnt_next = cnt_reg;
        bal_next = bal_reg;
        bwb_next = bwb_reg;
        is_eol   = (item.data_byte == CH_LF) || (item.data_byte == CH_CR);

        if (item.mode == MODE_DISCONNECT)
        begin
            if (cnt_reg != '0)
            begin
                res0 = '{kind: KIND_ABORT, out_byte: '0, frame_length: cnt_reg};
                n    = 2'd1;
            end
            cnt_next = '0;
            bal_next = '0;
            bwb_next = 1'b0;
        end
        else if (item.target_handle == control_handle)
        begin
            if (is_eol)
            begin
                if (cnt_reg != '0)
                begin
                    res0 = '{kind: KIND_COMPLETE, out_byte: '0, frame_length: cnt_reg};
                    n    = 2'd1;
                end
                cnt_next = '0;
                bal_next = '0;
                bwb_next = 1'b0;
            end
            else if (cnt_reg < MAX_CNT)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    bwb_next = (item.data_byte == CH_OPEN);
                end
                if (item.data_byte == CH_OPEN)
                begin
                    bal_next = bal_reg + BAL_W'(1);
                end
                else if (item.data_byte == CH_CLOSE)
                begin
                    bal_next = bal_reg - BAL_W'(1);
                end
                res0 = '{kind: KIND_PAYLOAD, out_byte: item.data_byte,
                         frame_length: cnt_next};
                n    = 2'd1;
            end

            // A balanced brace frame ends with its write chunk
            if (item.last_in_write && (cnt_next != '0) && bwb_next && (bal_next == '0))
            begin
                if (n == 2'd0)
                begin
                    res0 = '{kind: KIND_COMPLETE, out_byte: '0, frame_length: cnt_next};
                end
                else
                begin
                    res1 = '{kind: KIND_COMPLETE, out_byte: '0, frame_length: cnt_next};
                end
                n        = n + 2'd1;
                cnt_next = '0;
                bal_next = '0;
                bwb_next = 1'b0;
            end
        end

        pair = '{count: n, r0: res0, r1: res1};
    end

    // Frame state advances when the request leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            bal_reg <= '0;
            bwb_reg <= 1'b0;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_next;
            bal_reg <= bal_next;
            bwb_reg <= bwb_next;
        end
    end

endmodule

// ===== sv/nbcf_result_reg.sv =====
// Result register holding up to two results and sending them one per cycle while res_out is ready.
module nbcf_result_reg
    import nbcf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  pair_t pair,
    output logic  free,
    nbcf_res_if.source res_out
);

    pair_t pair_reg;
    logic  valid_reg;
    logic  idx_reg;
    logic  on_last;
    result_t cur;

    // Present the current slot and flag the final one
    assign cur     = idx_reg ? pair_reg.r1 : pair_reg.r0;
    assign on_last = idx_reg || (pair_reg.count == 2'd1);
    assign free    = !valid_reg || (res_out.ready && on_last);

    assign res_out.valid        = valid_reg;
    assign res_out.kind         = cur.kind;
    assign res_out.out_byte     = cur.out_byte;
    assign res_out.frame_length = cur.frame_length;
    assign res_out.last         = on_last;

    // Control: load a new pair or step through the held one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (valid_reg && res_out.ready)
        begin
            if (on_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair;
        end
    end

endmodule

// ===== sv/newline_brace_command_framer.sv =====
// Top level of the newline and brace-count command framer.
//
//  Channel   Direction  Handshake      Carries
//  req_in    in         valid/ready    mode, target_handle, data_byte, last_in_write
//  res_out   out        valid/ready    kind, out_byte, frame_length, last
//  cfg       in         cfg_wr_en      control_handle (16 bits)
//
// One request is taken per cycle while the result register has room; its results
// pass from the input register through the result register. A request with a payload
// byte and a completion marker holds the result register until both results are sent.
// Reset clears the frame state, the control handle and both valid flags.
// A stall on res_out backs up through the result register into the input register.
module newline_brace_command_framer
    import nbcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    nbcf_req_if.sink            req_in,
    nbcf_res_if.source          res_out,
    input  logic                cfg_wr_en,
    input  logic [HANDLE_W-1:0] cfg_wr_data
);

    logic [HANDLE_W-1:0] handle_reg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  advance;
    logic  free;
    pair_t pair;

    // Control handle register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            handle_reg <= cfg_wr_data;
        end
    end

    // The held request leaves when its results have room
    assign advance      = in_valid_reg && ((pair.count == 2'd0) || free);
    assign req_in.ready = !in_valid_reg || advance;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_in.valid && req_in.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (req_in.valid && req_in.ready)
        begin
            item_reg <= '{mode: req_in.mode, target_handle: req_in.target_handle,
                          data_byte: req_in.data_byte, last_in_write: req_in.last_in_write};
        end
    end

    nbcf_frame_logic u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .control_handle (handle_reg),
        .item           (item_reg),
        .advance        (advance),
        .pair           (pair)
    );

    nbcf_result_reg u_result (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && (pair.count != 2'd0)),
        .pair    (pair),
        .free    (free),
        .res_out (res_out)
    );

endmodule

// ===== sv/nbcf_checker.sv =====
// Port-level checks on the framer's result channel, bound to the top level.
module nbcf_checker
    import nbcf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [KIND_W-1:0] kind,
    input logic [BYTE_W-1:0] out_byte,
    input logic [CNT_W-1:0]  frame_length,
    input logic              last
);

    // A stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(out_byte)
            && $stable(frame_length) && $stable(last))
        else $error("stalled result changed");

    // Markers carry no byte and always end their request's results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_COMPLETE || kind == KIND_ABORT)
            |-> (out_byte == '0) && last)
        else $error("marker with byte or not last");

    // Only defined kinds appear
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (kind == KIND_PAYLOAD || kind == KIND_COMPLETE || kind == KIND_ABORT))
        else $error("undefined result kind");

    // Frame lengths are never zero and never past the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (frame_length != '0) && (frame_length <= MAX_CNT))
        else $error("frame length out of range");

    // A payload result that is not last is followed by its completion marker
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && (kind == KIND_PAYLOAD) && !last
            |=> res_valid && (kind == KIND_COMPLETE) && last)
        else $error("missing completion after payload");

endmodule

bind newline_brace_command_framer nbcf_checker u_nbcf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_out.valid),
    .res_ready    (res_out.ready),
    .kind         (res_out.kind),
    .out_byte     (res_out.out_byte),
    .frame_length (res_out.frame_length),
    .last         (res_out.last)
);

// ===== bench/tb_newline_brace_command_framer.sv =====
// Self-checking testbench for the newline and brace-count command framer.
`timescale 1ns / 1ps

module tb_newline_brace_command_framer;
    import nbcf_pkg::*;

    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    // One expected or observed result with its last flag
    typedef struct packed {
        result_t body;
        logic    last;
    } framer_out_t;

    logic clk;
    logic rst_n;
    logic                cfg_wr_en;
    logic [HANDLE_W-1:0] cfg_wr_data;

    nbcf_req_if req_ch();
    nbcf_res_if res_ch();

    newline_brace_command_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_in      (req_ch),
        .res_out     (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Pending requests and the results they are predicted to cause
    item_t       pending_requests[$];
    framer_out_t expected_results[$];

    int reqs_queued = 0;
    int live_queued = 0;
    int req_accepts = 0;
    int res_accepts = 0;
    int fail_count  = 0;
    int handle_writes = 0;
    int payloads_seen = 0;
    int frames_completed = 0;
    int frames_aborted = 0;

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int long_hold_requests = 0;
    int stall_cycles = 0;

    // Generator's view of the control handle
    logic [HANDLE_W-1:0] cur_handle = '0;

    // Predictor state
    logic [HANDLE_W-1:0]     ctl_handle = '0;
    logic [CNT_W-1:0]        frame_len = '0;
    logic signed [BAL_W-1:0] brace_bal = '0;
    logic                    opened_with_brace = 1'b0;

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH at result %0d: %0s", res_accepts, msg);
    endtask

    function automatic framer_out_t result_of(input logic [KIND_W-1:0] k,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [CNT_W-1:0] len);
        framer_out_t o;
        o.body.kind = k;
        o.body.out_byte = b;
        o.body.frame_length = len;
        o.last = 1'b0;
        return o;
    endfunction

    // Work out the results of one accepted request and advance the frame state.
    task automatic predict_framing(input item_t it);
        framer_out_t caused[2];
        int n;
        n = 0;
        if (it.mode == MODE_DISCONNECT) begin
            if (frame_len != 0) begin
                caused[n] = result_of(KIND_ABORT, '0, frame_len);
                n++;
            end
            frame_len = '0;
            brace_bal = '0;
            opened_with_brace = 1'b0;
        end else if (it.target_handle == ctl_handle) begin
            if (it.data_byte == CH_LF || it.data_byte == CH_CR) begin
                if (frame_len != 0) begin
                    caused[n] = result_of(KIND_COMPLETE, '0, frame_len);
                    n++;
                end
                frame_len = '0;
                brace_bal = '0;
                opened_with_brace = 1'b0;
            end else if (frame_len < MAX_CNT) begin
                frame_len = frame_len + 1'b1;
                if (frame_len == 1)
                    opened_with_brace = (it.data_byte == CH_OPEN);
                if (it.data_byte == CH_OPEN)
                    brace_bal = brace_bal + BAL_W'(1);
                else if (it.data_byte == CH_CLOSE)
                    brace_bal = brace_bal - BAL_W'(1);
                caused[n] = result_of(KIND_PAYLOAD, it.data_byte, frame_len);
                n++;
            end
            // A brace-balanced frame also ends at the close of a write chunk.
            if (it.last_in_write && frame_len != 0 && opened_with_brace && brace_bal == 0)
            begin
                caused[n] = result_of(KIND_COMPLETE, '0, frame_len);
                n++;
                frame_len = '0;
                brace_bal = '0;
                opened_with_brace = 1'b0;
            end
        end
        if (n > 0)
            caused[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(caused[i]);
    endtask

    // Predict on accepted requests and check accepted results.
    always @(posedge clk) begin
        framer_out_t want;
        if (rst_n) begin
            if (cfg_wr_en)
                ctl_handle = cfg_wr_data;
            if (req_ch.valid && req_ch.ready) begin
                req_accepts++;
                predict_framing({req_ch.mode, req_ch.target_handle, req_ch.data_byte,
                                 req_ch.last_in_write});
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d len %0d",
                                              res_ch.kind, res_ch.frame_length));
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.kind !== want.body.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  res_ch.kind, want.body.kind));
                    if (res_ch.out_byte !== want.body.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  res_ch.out_byte, want.body.out_byte));
                    if (res_ch.frame_length !== want.body.frame_length)
                        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                                  res_ch.frame_length,
                                                  want.body.frame_length));
                    if (res_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  res_ch.last, want.last));
                    if (want.body.kind == KIND_PAYLOAD)
                        payloads_seen++;
                    else if (want.body.kind == KIND_COMPLETE)
                        frames_completed++;
                    else
                        frames_aborted++;
                end
                res_accepts++;
            end
        end
    end

    // Request driver: one item at a time, with a drawn gap before the next.
    int issued = 0;
    int tx_wait = 0;
    always @(negedge clk) begin
        item_t nxt;
        if (rst_n) begin
            if (!req_ch.valid || req_accepts == issued) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    req_ch.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    nxt = pending_requests.pop_front();
                    req_ch.mode          <= nxt.mode;
                    req_ch.target_handle <= nxt.target_handle;
                    req_ch.data_byte     <= nxt.data_byte;
                    req_ch.last_in_write <= nxt.last_in_write;
                    req_ch.valid         <= 1'b1;
                    issued++;
                    tx_wait = $urandom_range(0, tx_gap_max);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: a drawn stall after each result, plus long hold-offs on request.
    int rx_seen = 0;
    int rx_wait = 0;
    int hold_left = 0;
    int long_hold_served = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (res_accepts != rx_seen) begin
                rx_seen = res_accepts;
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (long_hold_served != long_hold_requests) begin
                long_hold_served = long_hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake or register write ends the run.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results still expected",
                     STALL_LIMIT, expected_results.size());
            $display("tb_newline_brace_command_framer: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_request(input item_t it);
        pending_requests.push_back(it);
        reqs_queued++;
        if (it.mode == MODE_DISCONNECT || it.target_handle == cur_handle)
            live_queued++;
    endtask

    function automatic item_t byte_req(input logic [HANDLE_W-1:0] h,
                                       input logic [BYTE_W-1:0] b, input logic l);
        item_t it;
        it.mode = MODE_BYTE;
        it.target_handle = h;
        it.data_byte = b;
        it.last_in_write = l;
        return it;
    endfunction

    function automatic item_t disconnect_req();
        item_t it;
        it.mode = MODE_DISCONNECT;
        it.target_handle = HANDLE_W'($urandom);
        it.data_byte = BYTE_W'($urandom);
        it.last_in_write = $urandom_range(0, 1) == 1;
        return it;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == CH_LF || b == CH_CR || b == CH_OPEN || b == CH_CLOSE)
            b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] framing_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 3))
            0:       b = CH_LF;
            1:       b = CH_CR;
            2:       b = CH_OPEN;
            default: b = CH_CLOSE;
        endcase
        return b;
    endfunction

    function automatic logic [HANDLE_W-1:0] other_handle();
        logic [HANDLE_W-1:0] h;
        h = HANDLE_W'($urandom);
        while (h == cur_handle)
            h = HANDLE_W'($urandom);
        return h;
    endfunction

    task automatic write_control_handle(input logic [HANDLE_W-1:0] h);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= h;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        cur_handle = h;
        handle_writes++;
    endtask

    // Wait for every request to be taken and every result to arrive, then let
    // requests that cause no result pass through the pipeline.
    task automatic wait_drained();
        while (req_accepts != reqs_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A brace-delimited command split into write chunks at random points, or cut short by a disconnect.
    task automatic queue_brace_message(input bit cut_short);
        int depth;
        int body;
        int pick;
        logic [BYTE_W-1:0] b;
        depth = 1;
        body = $urandom_range(0, 12);
        queue_request(byte_req(cur_handle, CH_OPEN, $urandom_range(0, 3) == 0));
        for (int i = 0; i < body; i++) begin
            pick = $urandom_range(0, 5);
            if (pick == 0 && depth < 4) begin
                b = CH_OPEN;
                depth++;
            end else if (pick == 1 && depth > 1) begin
                b = CH_CLOSE;
                depth--;
            end else begin
                b = text_byte();
            end
            queue_request(byte_req(cur_handle, b, $urandom_range(0, 3) == 0));
            if ($urandom_range(0, 15) == 0)
                queue_request(byte_req(other_handle(), BYTE_W'($urandom),
                                       $urandom_range(0, 1) == 1));
        end
        if (cut_short) begin
            queue_request(disconnect_req());
        end else begin
            for (int i = 1; i < depth; i++)
                queue_request(byte_req(cur_handle, CH_CLOSE, $urandom_range(0, 3) == 0));
            // Mostly the closing brace ends the write; otherwise a newline ends the frame.
            if ($urandom_range(0, 7) != 0) begin
                queue_request(byte_req(cur_handle, CH_CLOSE, 1'b1));
            end else begin
                queue_request(byte_req(cur_handle, CH_CLOSE, 1'b0));
                queue_request(byte_req(cur_handle, $urandom_range(0, 1) ? CH_LF : CH_CR,
                                       $urandom_range(0, 1) == 1));
            end
        end
    endtask

    // A text line ending in CR or LF; zero length gives an empty line.
    task automatic queue_text_line();
        int len;
        logic [BYTE_W-1:0] b;
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            while (b == CH_LF || b == CH_CR)
                b = BYTE_W'($urandom_range(0, 255));
            queue_request(byte_req(cur_handle, b, $urandom_range(0, 3) == 0));
        end
        queue_request(byte_req(cur_handle, $urandom_range(0, 1) ? CH_LF : CH_CR,
                               $urandom_range(0, 1) == 1));
    endtask

    // Arbitrary requests mixing framing characters, foreign handles and disconnects.
    task automatic queue_noise();
        int cnt;
        logic [BYTE_W-1:0] b;
        cnt = $urandom_range(1, 6);
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_request(disconnect_req());
            end else begin
                b = ($urandom_range(0, 2) == 0) ? framing_byte() : 8'($urandom);
                queue_request(byte_req($urandom_range(0, 1) ? cur_handle : other_handle(),
                                       b, $urandom_range(0, 1) == 1));
            end
        end
    endtask

    task automatic random_phase(input int n);
        int goal;
        int pick;
        goal = live_queued + n;
        while (live_queued < goal) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
                queue_brace_message(1'b0);
            else if (pick <= 6)
                queue_text_line();
            else if (pick == 7)
                queue_brace_message(1'b1);
            else if (pick == 8)
                queue_noise();
            else
                queue_request(disconnect_req());
        end
    endtask

    // Directed cases on the reset value of the control handle.
    task automatic queue_directed();
        queue_request(item_t'{MODE_DISCONNECT, 16'hFFFF, 8'hFF, 1'b1});
        queue_request(byte_req(16'h0000, CH_LF, 1'b1));
        queue_request(byte_req(16'hFFFF, 8'h41, 1'b1));
        // Brace frame closed at a chunk end, with a foreign byte inside it.
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b0));
        queue_request(byte_req(16'h0000, 8'h00, 1'b1));
        queue_request(byte_req(16'hFFFF, CH_CLOSE, 1'b1));
        queue_request(byte_req(16'h0000, CH_CLOSE, 1'b1));
        // Balanced but not opened by a brace: only the CR ends it.
        queue_request(byte_req(16'h0000, 8'hFF, 1'b0));
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b1));
        queue_request(byte_req(16'h0000, CH_CLOSE, 1'b1));
        queue_request(byte_req(16'h0000, CH_CR, 1'b1));
        // Balance goes negative and returns to zero at a chunk end.
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b0));
        queue_request(byte_req(16'h0000, CH_CLOSE, 1'b0));
        queue_request(byte_req(16'h0000, CH_CLOSE, 1'b1));
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b1));
        // Partial frame aborted by a disconnect.
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b1));
        queue_request(byte_req(16'h0000, 8'h7C, 1'b0));
        queue_request(item_t'{MODE_DISCONNECT, 16'h0000, 8'h00, 1'b0});
        // Newline that is also a chunk end completes once.
        queue_request(byte_req(16'h0000, 8'h61, 1'b0));
        queue_request(byte_req(16'h0000, CH_OPEN, 1'b0));
        queue_request(byte_req(16'h0000, CH_LF, 1'b1));
        queue_request(byte_req(16'h0000, CH_CR, 1'b0));
    endtask

    // Main sequence: reset, directed cases, then random phases per handle setting.
    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_BYTE;
        req_ch.target_handle = '0;
        req_ch.data_byte = '0;
        req_ch.last_in_write = 1'b0;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_max = 3;
        rx_gap_max = 3;
        queue_directed();
        wait_drained();

        // Full idling on both sides, with one long output stall mid-phase.
        write_control_handle(16'hFFFF);
        tx_gap_max = 7;
        rx_gap_max = 7;
        random_phase(200);
        while (req_accepts < reqs_queued - 300)
            @(negedge clk);
        @(posedge clk);
        long_hold_requests++;
        wait_drained();

        // Back-to-back traffic with no idling.
        write_control_handle(16'($urandom_range(1, 16'hFFFE)));
        tx_gap_max = 0;
        rx_gap_max = 0;
        random_phase(200);
        wait_drained();

        write_control_handle(16'($urandom_range(1, 16'hFFFE)));
        tx_gap_max = 7;
        rx_gap_max = 0;
        random_phase(200);
        wait_drained();

        write_control_handle(16'($urandom_range(1, 16'hFFFE)));
        tx_gap_max = 0;
        rx_gap_max = 7;
        random_phase(200);
        wait_drained();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("Run covered %0d requests over %0d handle settings: %0d payload bytes,",
                 req_accepts, handle_writes + 1, payloads_seen);
        $display("%0d frames completed, %0d aborted, and an %0d-cycle output stall.",
                 frames_completed, frames_aborted, LONG_HOLD);
        if (fail_count == 0)
            $display("tb_newline_brace_command_framer: PASS");
        else
            $display("tb_newline_brace_command_framer: FAIL");
        $finish;
    end

endmodule
